/* sv/dlr_pkg.sv */
// shared types and constants for the dda line rasterizer
package dlr_pkg;

  // item kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // load item accepted
    logic step;      // step item accepted while a line is active
    logic div_iter;  // run one division iteration
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_active;  // steps remain on the current line
    logic load_zero;    // endpoints on the input ports are equal
    logic div_done;     // final division iteration this cycle
    logic out_free;     // output register can take a new item
  } sts_t;

endpackage

/* sv/dda_line_rasterizer_top.sv */
// top level of the dda line rasterizer
// dda line rasterizer: a load item (kind 0) takes two signed endpoints and
// emits the start point at once; a step item (kind 1) emits the next pixel
// of the line, and the pixel equal to the end point carries last_point.
// step items after the last point, or before any load, are taken and give
// no item. a line streams at one pixel per clock while the output side
// keeps up. a load emits the start point and then runs the shared
// restoring divider, which finds both per-axis increments one quotient bit
// per cycle; in_ready stays low while it runs. a load with equal endpoints
// needs no division. the output register lets a new item in during the
// same cycle that the waiting result is taken.
// increments are signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero; pixels are the accumulators rounded half up.
module dda_line_rasterizer_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         last_point
);

  dlr_pkg::cmd_t cmd;
  dlr_pkg::sts_t sts;

  // sequencing: accept, division run
  dlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and result register
  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

endmodule

/* sv/dlr_ctrl.sv */
// controller state machine for the dda line rasterizer
module dlr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          kind,
  output logic          in_ready,
  input  dlr_pkg::sts_t sts,
  output dlr_pkg::cmd_t cmd
);

  dlr_pkg::state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.div_iter = 1'b0;
    accept       = 1'b0;
    unique case (state)
      dlr_pkg::S_IDLE: begin
        in_ready = sts.out_free;
        accept   = in_valid && sts.out_free;
        cmd.load = accept && (kind == dlr_pkg::KIND_LOAD);
        // a step with no active line is taken and dropped
        cmd.step = accept && (kind == dlr_pkg::KIND_STEP) && sts.line_active;
        if (cmd.load && !sts.load_zero) begin
          state_next = dlr_pkg::S_DIV;
        end
      end
      dlr_pkg::S_DIV: begin
        cmd.div_iter = 1'b1;
        if (sts.div_done) begin
          state_next = dlr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dlr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/dlr_datapath.sv */
// datapath for the dda line rasterizer: divider, accumulators, output register
module dlr_datapath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  dlr_pkg::cmd_t                cmd,
  output dlr_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic                         last_point
);

  localparam int DW = COORD_BITS + 1;              // delta and remainder
  localparam int AW = COORD_BITS + 1 + FRAC_BITS;  // accumulator
  localparam int SW = FRAC_BITS + 2;               // increment
  localparam int QW = FRAC_BITS + 1;               // quotient magnitude
  localparam int CW = $clog2(FRAC_BITS + 1);       // iteration counter

  // load-time deltas
  logic [DW-1:0] dx, dy, adx, ady, steps;

  // divider state
  logic [COORD_BITS-1:0] divisor;
  logic [DW-1:0]         rem_x, rem_y;
  logic [QW-1:0]         quo_x, quo_y;
  logic                  neg_x, neg_y;
  logic [CW-1:0]         div_cnt;
  logic                  ge_x, ge_y;
  logic [DW-1:0]         sub_x, sub_y;
  logic [QW-1:0]         qfin_x, qfin_y;

  // line state; accumulators carry a built-in half for rounding
  logic [AW-1:0]         x_accum, y_accum;
  logic [AW-1:0]         x_accum_next, y_accum_next;
  logic [SW-1:0]         x_step, y_step;
  logic [COORD_BITS-1:0] steps_left;

  always_comb begin
    dx    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    adx   = dx[DW-1] ? (~dx + DW'(1)) : dx;
    ady   = dy[DW-1] ? (~dy + DW'(1)) : dy;
    steps = (adx > ady) ? adx : ady;

    ge_x   = rem_x >= {1'b0, divisor};
    ge_y   = rem_y >= {1'b0, divisor};
    sub_x  = ge_x ? (rem_x - {1'b0, divisor}) : rem_x;
    sub_y  = ge_y ? (rem_y - {1'b0, divisor}) : rem_y;
    qfin_x = {quo_x[QW-2:0], ge_x};
    qfin_y = {quo_y[QW-2:0], ge_y};

    x_accum_next = x_accum + {{(AW-SW){x_step[SW-1]}}, x_step};
    y_accum_next = y_accum + {{(AW-SW){y_step[SW-1]}}, y_step};

    sts.line_active = steps_left != '0;
    sts.load_zero   = steps == '0;
    sts.div_done    = cmd.div_iter && (div_cnt == CW'(FRAC_BITS));
    sts.out_free    = !out_valid || out_ready;
  end

  // restoring division, one quotient bit per cycle for both axes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor <= steps[COORD_BITS-1:0];
      rem_x   <= adx;
      rem_y   <= ady;
      quo_x   <= '0;
      quo_y   <= '0;
      neg_x   <= dx[DW-1];
      neg_y   <= dy[DW-1];
      div_cnt <= '0;
    end else if (cmd.div_iter) begin
      rem_x   <= {sub_x[DW-2:0], 1'b0};
      rem_y   <= {sub_y[DW-2:0], 1'b0};
      quo_x   <= qfin_x;
      quo_y   <= qfin_y;
      div_cnt <= div_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum    <= '0;
      y_accum    <= '0;
      x_step     <= '0;
      y_step     <= '0;
      steps_left <= '0;
    end else begin
      if (cmd.load) begin
        x_accum    <= {start_x[COORD_BITS-1], start_x, 1'b1, (FRAC_BITS-1)'(0)};
        y_accum    <= {start_y[COORD_BITS-1], start_y, 1'b1, (FRAC_BITS-1)'(0)};
        x_step     <= '0;
        y_step     <= '0;
        steps_left <= steps[COORD_BITS-1:0];
      end else if (cmd.step) begin
        x_accum    <= x_accum_next;
        y_accum    <= y_accum_next;
        steps_left <= steps_left - COORD_BITS'(1);
      end
      if (sts.div_done) begin
        x_step <= neg_x ? (~SW'(qfin_x) + SW'(1)) : SW'(qfin_x);
        y_step <= neg_y ? (~SW'(qfin_y) + SW'(1)) : SW'(qfin_y);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load || cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      point_x    <= start_x;
      point_y    <= start_y;
      last_point <= steps == '0;
    end else if (cmd.step) begin
      point_x    <= x_accum_next[FRAC_BITS +: COORD_BITS];
      point_y    <= y_accum_next[FRAC_BITS +: COORD_BITS];
      last_point <= steps_left == COORD_BITS'(1);
    end
  end

endmodule

/* sv/dlr_checker.sv */
// port-level assertions for the dda line rasterizer, bound to the top level
module dlr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         kind,
  input logic signed [COORD_BITS-1:0] start_x,
  input logic signed [COORD_BITS-1:0] start_y,
  input logic signed [COORD_BITS-1:0] end_x,
  input logic signed [COORD_BITS-1:0] end_y,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] point_x,
  input logic signed [COORD_BITS-1:0] point_y,
  input logic                         last_point
);

  logic load_acc;
  assign load_acc = in_valid && in_ready && (kind == dlr_pkg::KIND_LOAD);

  // a load item emits its start point in the next cycle
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> out_valid && point_x == $past(start_x) && point_y == $past(start_y))
    else $error("load item did not emit its start point");

  // equal endpoints give a single point flagged last
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    load_acc && start_x == end_x && start_y == end_y |=> last_point)
    else $error("degenerate line start point not flagged last");

  // distinct endpoints start the divider, which holds off new items
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    load_acc && (start_x != end_x || start_y != end_y) |=> !in_ready && !last_point)
    else $error("divider did not hold off input after a load item");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(last_point))
    else $error("stalled result changed");

endmodule

bind dda_line_rasterizer_top dlr_checker #(.COORD_BITS(COORD_BITS)) u_dlr_checker (.*);

/* test/dda_line_rasterizer_top_tb.sv */
// self-checking testbench for the dda line rasterizer top level
module dda_line_rasterizer_top_tb;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = COORD_BITS + 1 + FRAC_BITS;
  localparam int INC_BITS   = 2 + FRAC_BITS;
  localparam int ITEM_TARGET = 1050;
  localparam int PHASE_LEN   = 350;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } pixel_t;

  // tracks the line in flight and the pixels the block still owes
  class line_tracker;
    logic signed [ACC_BITS-1:0]   x_acc;
    logic signed [ACC_BITS-1:0]   y_acc;
    logic signed [INC_BITS-1:0]   x_inc;
    logic signed [INC_BITS-1:0]   y_inc;
    logic        [COORD_BITS-1:0] steps_left;
    pixel_t                       pixels_due[$];
    int                           errors;

    function new();
      x_acc = '0;
      y_acc = '0;
      x_inc = '0;
      y_inc = '0;
      steps_left = '0;
      errors = 0;
    endfunction

    // delta / span with FRAC_BITS fraction bits, truncated toward zero
    function logic signed [INC_BITS-1:0] slope(int delta, int span);
      longint mag;
      mag = (delta < 0) ? -delta : delta;
      mag = (mag << FRAC_BITS) / span;
      return INC_BITS'((delta < 0) ? -mag : mag);
    endfunction

    // round half up: floor(acc + 0.5)
    function logic signed [COORD_BITS-1:0] round_coord(logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] half;
      logic signed [ACC_BITS-1:0] t;
      half = ACC_BITS'(1) <<< (FRAC_BITS - 1);
      t = acc + half;
      t = t >>> FRAC_BITS;
      return t[COORD_BITS-1:0];
    endfunction

    function void take_item(logic k, logic signed [COORD_BITS-1:0] sx,
                            logic signed [COORD_BITS-1:0] sy,
                            logic signed [COORD_BITS-1:0] ex,
                            logic signed [COORD_BITS-1:0] ey);
      int     dx;
      int     dy;
      int     adx;
      int     ady;
      int     span;
      pixel_t p;
      if (k == dlr_pkg::KIND_LOAD) begin
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        span = (adx > ady) ? adx : ady;
        if (span == 0) begin
          x_inc = '0;
          y_inc = '0;
        end else begin
          x_inc = slope(dx, span);
          y_inc = slope(dy, span);
        end
        x_acc = ACC_BITS'(sx);
        y_acc = ACC_BITS'(sy);
        x_acc = x_acc <<< FRAC_BITS;
        y_acc = y_acc <<< FRAC_BITS;
        steps_left = span[COORD_BITS-1:0];
        p.x = sx;
        p.y = sy;
        p.last = (span == 0);
        pixels_due.push_back(p);
      end else if (steps_left != 0) begin
        x_acc = x_acc + ACC_BITS'(x_inc);
        y_acc = y_acc + ACC_BITS'(y_inc);
        steps_left = steps_left - COORD_BITS'(1);
        p.x = round_coord(x_acc);
        p.y = round_coord(y_acc);
        p.last = (steps_left == 0);
        pixels_due.push_back(p);
      end
    endfunction

    function void check_pixel(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y, logic last);
      pixel_t p;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel x=%0d y=%0d last=%0b", x, y, last);
      end else begin
        p = pixels_due.pop_front();
        if (p.x !== x || p.y !== y || p.last !== last) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     p.x, p.y, p.last, x, y, last);
        end
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         kind = dlr_pkg::KIND_LOAD;
  logic signed [COORD_BITS-1:0] start_x = '0;
  logic signed [COORD_BITS-1:0] start_y = '0;
  logic signed [COORD_BITS-1:0] end_x = '0;
  logic signed [COORD_BITS-1:0] end_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  line_tracker book;
  int          items_sent = 0;
  int          send_idle = 32;
  int          recv_idle = 85;
  int          idle_cycles = 0;

  dda_line_rasterizer_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .last_point(last_point)
  );

  always #5 clk = ~clk;

  function automatic int rand_coord();
    return int'($urandom_range(4095)) + COORD_MIN;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // present one item, holding it until the block takes it
  task automatic send_item(logic k, int sx, int sy, int ex, int ey);
    if (items_sent < PHASE_LEN) begin
      send_idle = 32;
      recv_idle = 85;
    end else if (items_sent < 2 * PHASE_LEN) begin
      send_idle = 85;
      recv_idle = 32;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while (int'($urandom_range(99)) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_x <= sx[COORD_BITS-1:0];
    start_y <= sy[COORD_BITS-1:0];
    end_x <= ex[COORD_BITS-1:0];
    end_y <= ey[COORD_BITS-1:0];
    do @(posedge clk); while (!in_ready);
    book.take_item(k, sx[COORD_BITS-1:0], sy[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                   ey[COORD_BITS-1:0]);
    items_sent++;
  endtask

  // step item with junk on the endpoint fields, which it must ignore
  task automatic send_step();
    send_item(dlr_pkg::KIND_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic random_burst();
    int pick;
    int sx;
    int sy;
    int ex;
    int ey;
    int reach;
    int adx;
    int ady;
    int span;
    int count;
    pick = $urandom_range(99);
    sx = rand_coord();
    sy = rand_coord();
    if (pick < 80) begin
      // short well-formed line, usually walked to its end
      reach = ($urandom_range(9) < 7) ? 12 : 200;
      ex = clamp_coord(sx + int'($urandom_range(2 * reach)) - reach);
      ey = clamp_coord(sy + int'($urandom_range(2 * reach)) - reach);
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      span = (adx > ady) ? adx : ady;
      send_item(dlr_pkg::KIND_LOAD, sx, sy, ex, ey);
      if ($urandom_range(99) < 85)
        count = span + int'($urandom_range(2));
      else
        count = $urandom_range(span);
      repeat (count) send_step();
    end else if (pick < 88) begin
      // long line, cut short by the next load
      send_item(dlr_pkg::KIND_LOAD, sx, sy, rand_coord(), rand_coord());
      repeat ($urandom_range(12)) send_step();
    end else if (pick < 92) begin
      send_item(dlr_pkg::KIND_LOAD, sx, sy, sx, sy);
      repeat ($urandom_range(2)) send_step();
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
    end
  endtask

  // result side: random back-pressure and checking of every taken pixel
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        book.check_pixel(point_x, point_y, last_point);
      out_ready <= (int'($urandom_range(99)) >= recv_idle);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("dda_line_rasterizer_top_tb: errors");
    $finish;
  end

  initial begin
    book = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // steps before any load give nothing
    send_step();
    send_step();
    // equal endpoints: start point only, flagged last
    send_item(dlr_pkg::KIND_LOAD, 5, -7, 5, -7);
    send_step();
    // full-range diagonal, then a load in the middle of it
    send_item(dlr_pkg::KIND_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    repeat (3) send_step();
    send_item(dlr_pkg::KIND_LOAD, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    repeat (2) send_step();
    send_item(dlr_pkg::KIND_LOAD, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    // shallow line walked past its end
    send_item(dlr_pkg::KIND_LOAD, 0, 0, 3, -2);
    repeat (4) send_step();
    // steep line with half-pixel increments
    send_item(dlr_pkg::KIND_LOAD, 1, 1, -1, 5);
    repeat (5) send_step();

    while (items_sent < ITEM_TARGET) random_burst();
    in_valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0)
      $display("dda_line_rasterizer_top_tb: clean");
    else
      $display("dda_line_rasterizer_top_tb: errors");
    $finish;
  end

endmodule
